// File: hw/rtl/etsc_pkg.sv
// ----------------------------------------------------------------------------
// etsc_pkg
// Shared types and constants for the extreme-trim spec check: request
// payloads, verdict codes and the snapshot flags passed between modules.
// ----------------------------------------------------------------------------
package etsc_pkg;

    localparam int MAX_ITEMS_DEF   = 256;
    localparam int HEIGHT_BITS_DEF = 16;

    localparam int HEIGHT_W  = 16;
    localparam int SPEC_W    = 16;
    localparam int INDEX_W   = 8;
    localparam int VERDICT_W = 3;

    localparam logic [SPEC_W-1:0] RANGE_SPEC_RESET = 16'd1000;

    typedef enum logic [VERDICT_W-1:0] {
        VERDICT_IN_SPEC       = 3'd0,
        VERDICT_DROP_MIN      = 3'd1,
        VERDICT_DROP_MAX      = 3'd2,
        VERDICT_DROP_BOTH     = 3'd3,
        VERDICT_UNCORRECTABLE = 3'd4,
        VERDICT_TIE           = 3'd5
    } verdict_t;

    typedef struct packed {
        logic [HEIGHT_W-1:0] height;
        logic                last;
    } sample_t;

    typedef struct packed {
        verdict_t            verdict;
        logic [INDEX_W-1:0]  first_index;
        logic [INDEX_W-1:0]  second_index;
        logic [SPEC_W-1:0]   full_range;
        logic                overflow;
    } result_t;

    // Status of the closed-set snapshot held by the tracker
    typedef struct packed {
        logic valid;
        logic ge2;
        logic ge3;
        logic overflow;
    } snap_flags_t;

endpackage

// File: hw/rtl/extreme_trim_spec_check.sv
// ----------------------------------------------------------------------------
// extreme_trim_spec_check
// Collects a set of height samples and, on the last one, decides whether the
// spread is in spec or can be brought under spec by dropping the minimum, the
// maximum or both.
//
//   channel   direction  handshake                payload
//   sample    in         sample_valid/stall       etsc_pkg::sample_t
//   result    out        result_valid/stall       etsc_pkg::result_t
//   cfg       in         cfg_valid/cfg_ready      range_spec, 16 bit
//
// A sample request is taken in every cycle in which sample_stall is low. The
// result of a set passes through the input register, the set snapshot and
// the result register before it appears on the result port.
// Reset sets range_spec to 1000 and clears the running set.
// A stalled result holds; samples keep flowing and one more closed set waits
// in the snapshot. The last sample of the set after that raises sample_stall.
// ----------------------------------------------------------------------------
module extreme_trim_spec_check #(
    parameter int MAX_ITEMS   = etsc_pkg::MAX_ITEMS_DEF,
    parameter int HEIGHT_BITS = etsc_pkg::HEIGHT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               sample_valid,
    output logic                               sample_stall,
    input  etsc_pkg::sample_t                  sample,
    output logic                               result_valid,
    input  logic                               result_stall,
    output etsc_pkg::result_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [etsc_pkg::SPEC_W-1:0]        cfg_data
);

    localparam int POS_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CMP_W = (HEIGHT_BITS > etsc_pkg::SPEC_W) ? HEIGHT_BITS
                                                            : etsc_pkg::SPEC_W;

    logic [etsc_pkg::SPEC_W-1:0] range_spec_reg;

    logic                   s1_valid_reg, s1_last_reg;
    logic [HEIGHT_BITS-1:0] s1_height_reg;
    logic [31:0]            height_ext;

    logic out_free, snap_free, s1_move, s1_open, accept, snap_pop;

    etsc_pkg::snap_flags_t  snap_flags;
    logic [HEIGHT_BITS-1:0] snap_lo, snap_sl, snap_hi, snap_sh;
    logic [POS_W-1:0]       snap_lpos, snap_hpos;

    logic [HEIGHT_BITS-1:0] full, r_min, r_max, r_both;
    logic [CMP_W-1:0]       spec_ext, full_ext, rmin_ext, rmax_ext, rboth_ext;
    logic [31:0]            full_w, lpos_w, hpos_w;

    logic                   res_valid_reg;
    etsc_pkg::result_t      res_reg, res_next;

    // ---- handshake ----
    assign out_free     = !res_valid_reg || !result_stall;
    assign snap_free    = !snap_flags.valid || out_free;
    assign s1_move      = s1_valid_reg && (!s1_last_reg || snap_free);
    assign s1_open      = !s1_valid_reg || s1_move;
    assign sample_stall = !s1_open;
    assign accept       = sample_valid && s1_open;
    assign snap_pop     = snap_flags.valid && out_free;
    assign cfg_ready    = 1'b1;

    assign height_ext = 32'(sample.height);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_spec_reg <= etsc_pkg::RANGE_SPEC_RESET;
            s1_valid_reg   <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                range_spec_reg <= cfg_data;
            end
            if (s1_open)
            begin
                s1_valid_reg <= sample_valid;
            end
            if (out_free)
            begin
                res_valid_reg <= snap_flags.valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_height_reg <= height_ext[HEIGHT_BITS-1:0];
            s1_last_reg   <= sample.last;
        end
        if (snap_pop)
        begin
            res_reg <= res_next;
        end
    end

    etsc_tracker #(
        .MAX_ITEMS   (MAX_ITEMS),
        .HEIGHT_BITS (HEIGHT_BITS)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (s1_move),
        .take_height (s1_height_reg),
        .take_last   (s1_last_reg),
        .snap_pop    (snap_pop),
        .snap_flags  (snap_flags),
        .snap_lo     (snap_lo),
        .snap_sl     (snap_sl),
        .snap_hi     (snap_hi),
        .snap_sh     (snap_sh),
        .snap_lpos   (snap_lpos),
        .snap_hpos   (snap_hpos)
    );

    // ---- verdict on the snapshot ----
    assign full   = snap_hi - snap_lo;
    assign r_min  = snap_flags.ge2 ? (snap_hi - snap_sl) : '0;
    assign r_max  = snap_flags.ge2 ? (snap_sh - snap_lo) : '0;
    assign r_both = (snap_flags.ge3 && (snap_sh >= snap_sl)) ? (snap_sh - snap_sl) : '0;

    assign spec_ext  = CMP_W'(range_spec_reg);
    assign full_ext  = CMP_W'(full);
    assign rmin_ext  = CMP_W'(r_min);
    assign rmax_ext  = CMP_W'(r_max);
    assign rboth_ext = CMP_W'(r_both);

    assign full_w = 32'(full);
    assign lpos_w = 32'(snap_lpos);
    assign hpos_w = 32'(snap_hpos);

    always_comb
    begin
        res_next              = '0;
        res_next.verdict      = etsc_pkg::VERDICT_IN_SPEC;
        res_next.full_range   = full_w[etsc_pkg::SPEC_W-1:0];
        res_next.overflow     = snap_flags.overflow;
        if (full_ext > spec_ext)
        begin
            // try drop min, then drop max, then drop both
            if (rmin_ext < spec_ext)
            begin
                res_next.verdict     = etsc_pkg::VERDICT_DROP_MIN;
                res_next.first_index = lpos_w[etsc_pkg::INDEX_W-1:0];
            end
            else if (rmin_ext == spec_ext)
            begin
                res_next.verdict = etsc_pkg::VERDICT_TIE;
            end
            else if (rmax_ext < spec_ext)
            begin
                res_next.verdict     = etsc_pkg::VERDICT_DROP_MAX;
                res_next.first_index = hpos_w[etsc_pkg::INDEX_W-1:0];
            end
            else if (rmax_ext == spec_ext)
            begin
                res_next.verdict = etsc_pkg::VERDICT_TIE;
            end
            else if (rboth_ext < spec_ext)
            begin
                res_next.verdict      = etsc_pkg::VERDICT_DROP_BOTH;
                res_next.first_index  = hpos_w[etsc_pkg::INDEX_W-1:0];
                res_next.second_index = lpos_w[etsc_pkg::INDEX_W-1:0];
            end
            else if (rboth_ext == spec_ext)
            begin
                res_next.verdict = etsc_pkg::VERDICT_TIE;
            end
            else
            begin
                res_next.verdict = etsc_pkg::VERDICT_UNCORRECTABLE;
            end
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

// File: hw/rtl/etsc_tracker.sv
// ----------------------------------------------------------------------------
// etsc_tracker
// Running two-smallest / two-largest tracker with first-occurrence positions
// of the extremes. On the last sample of a set the updated state is copied
// into a snapshot register for the verdict stage and the running set clears.
// ----------------------------------------------------------------------------
module etsc_tracker #(
    parameter int MAX_ITEMS   = etsc_pkg::MAX_ITEMS_DEF,
    parameter int HEIGHT_BITS = etsc_pkg::HEIGHT_BITS_DEF,
    localparam int CNT_W = $clog2(MAX_ITEMS + 1),
    localparam int POS_W = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  logic [HEIGHT_BITS-1:0]   take_height,
    input  logic                     take_last,
    input  logic                     snap_pop,
    output etsc_pkg::snap_flags_t    snap_flags,
    output logic [HEIGHT_BITS-1:0]   snap_lo,
    output logic [HEIGHT_BITS-1:0]   snap_sl,
    output logic [HEIGHT_BITS-1:0]   snap_hi,
    output logic [HEIGHT_BITS-1:0]   snap_sh,
    output logic [POS_W-1:0]         snap_lpos,
    output logic [POS_W-1:0]         snap_hpos
);

    logic [HEIGHT_BITS-1:0] lo_reg, sl_reg, hi_reg, sh_reg;
    logic [HEIGHT_BITS-1:0] lo_next, sl_next, hi_next, sh_next;
    logic [POS_W-1:0]       lpos_reg, hpos_reg, lpos_next, hpos_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   ovf_reg, ovf_next;

    logic [HEIGHT_BITS-1:0] snap_lo_reg, snap_sl_reg, snap_hi_reg, snap_sh_reg;
    logic [POS_W-1:0]       snap_lpos_reg, snap_hpos_reg;
    logic                   snap_valid_reg, snap_ge2_reg, snap_ge3_reg, snap_ovf_reg;

    logic [POS_W-1:0]       cur_pos;

    assign cur_pos = cnt_reg[POS_W-1:0];

    always_comb
    begin
        lo_next   = lo_reg;
        sl_next   = sl_reg;
        hi_next   = hi_reg;
        sh_next   = sh_reg;
        lpos_next = lpos_reg;
        hpos_next = hpos_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        if (32'(cnt_reg) >= 32'(MAX_ITEMS))
        begin
            // drop excess samples, flag them
            ovf_next = 1'b1;
        end
        else if (cnt_reg == '0)
        begin
            lo_next   = take_height;
            hi_next   = take_height;
            sl_next   = '1;
            sh_next   = '0;
            lpos_next = '0;
            hpos_next = '0;
            cnt_next  = cnt_reg + CNT_W'(1);
        end
        else
        begin
            if (take_height < lo_reg)
            begin
                sl_next   = lo_reg;
                lo_next   = take_height;
                lpos_next = cur_pos;
            end
            else if (take_height < sl_reg)
            begin
                sl_next = take_height;
            end
            if (take_height > hi_reg)
            begin
                sh_next   = hi_reg;
                hi_next   = take_height;
                hpos_next = cur_pos;
            end
            else if (take_height > sh_reg)
            begin
                sh_next = take_height;
            end
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg         <= '0;
            sl_reg         <= '0;
            hi_reg         <= '0;
            sh_reg         <= '0;
            lpos_reg       <= '0;
            hpos_reg       <= '0;
            cnt_reg        <= '0;
            ovf_reg        <= 1'b0;
            snap_valid_reg <= 1'b0;
        end
        else
        begin
            if (take && take_last)
            begin
                // close the set: snapshot it and start fresh
                lo_reg         <= '0;
                sl_reg         <= '0;
                hi_reg         <= '0;
                sh_reg         <= '0;
                lpos_reg       <= '0;
                hpos_reg       <= '0;
                cnt_reg        <= '0;
                ovf_reg        <= 1'b0;
                snap_valid_reg <= 1'b1;
            end
            else
            begin
                if (take)
                begin
                    lo_reg   <= lo_next;
                    sl_reg   <= sl_next;
                    hi_reg   <= hi_next;
                    sh_reg   <= sh_next;
                    lpos_reg <= lpos_next;
                    hpos_reg <= hpos_next;
                    cnt_reg  <= cnt_next;
                    ovf_reg  <= ovf_next;
                end
                if (snap_pop)
                begin
                    snap_valid_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && take_last)
        begin
            snap_lo_reg   <= lo_next;
            snap_sl_reg   <= sl_next;
            snap_hi_reg   <= hi_next;
            snap_sh_reg   <= sh_next;
            snap_lpos_reg <= lpos_next;
            snap_hpos_reg <= hpos_next;
            snap_ge2_reg  <= (32'(cnt_next) >= 32'd2);
            snap_ge3_reg  <= (32'(cnt_next) >= 32'd3);
            snap_ovf_reg  <= ovf_next;
        end
    end

    assign snap_flags.valid    = snap_valid_reg;
    assign snap_flags.ge2      = snap_ge2_reg;
    assign snap_flags.ge3      = snap_ge3_reg;
    assign snap_flags.overflow = snap_ovf_reg;
    assign snap_lo   = snap_lo_reg;
    assign snap_sl   = snap_sl_reg;
    assign snap_hi   = snap_hi_reg;
    assign snap_sh   = snap_sh_reg;
    assign snap_lpos = snap_lpos_reg;
    assign snap_hpos = snap_hpos_reg;

endmodule

// File: hw/rtl/etsc_checker.sv
// ----------------------------------------------------------------------------
// etsc_checker
// Port-level checks for the extreme-trim spec check, bound to the top level.
// ----------------------------------------------------------------------------
module etsc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        sample_stall,
    input logic                        result_valid,
    input logic                        result_stall,
    input etsc_pkg::result_t           result
);

    // hold a stalled result request
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // input backs up only behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> result_valid && result_stall)
        else $error("sample stalled with no result waiting");

    a_in_spec_idx: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.verdict == etsc_pkg::VERDICT_IN_SPEC ||
                         result.verdict == etsc_pkg::VERDICT_TIE ||
                         result.verdict == etsc_pkg::VERDICT_UNCORRECTABLE)
        |-> result.first_index == '0 && result.second_index == '0)
        else $error("index given without a trim");

    a_second_idx: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.verdict != etsc_pkg::VERDICT_DROP_BOTH
        |-> result.second_index == '0)
        else $error("second index set outside drop-both");

endmodule

bind extreme_trim_spec_check etsc_checker u_etsc_checker (.*);

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for extreme_trim_spec_check. Sends height sets, from
// single samples up to sets past the sample limit, under a series of
// range_spec values. A predictor in the scoreboard works out the verdict of
// every closed set. Each result that leaves the block is compared field by
// field with the oldest predicted verdict. Both channels idle in random
// bursts.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import etsc_pkg::*;

    localparam int MAX_SAMPLES = MAX_ITEMS_DEF;
    localparam int ITEM_TARGET = 1500;
    localparam int QUIET_AFTER = 1300;
    localparam int SETTLE      = 8;
    localparam int CYCLE_LIMIT = 400000;

    class spread_verdicts;
        logic [SPEC_W-1:0]   spec;
        logic [HEIGHT_W-1:0] lo, lo2, hi, hi2;
        logic [INDEX_W-1:0]  lo_pos, hi_pos;
        int                  count;
        logic                over;
        result_t             due[$];
        int                  errors;

        function new();
            spec   = RANGE_SPEC_RESET;
            errors = 0;
            clear_set();
        endfunction

        function void clear_set();
            lo     = '0;
            lo2    = '0;
            hi     = '0;
            hi2    = '0;
            lo_pos = '0;
            hi_pos = '0;
            count  = 0;
            over   = 1'b0;
        endfunction

        task report(string msg);
            $display("[%0t] verdict mismatch: %s", $time, msg);
            errors++;
        endtask

        function result_t judge_set();
            result_t             r;
            logic [HEIGHT_W-1:0] spread;
            r = '0;
            r.verdict    = VERDICT_IN_SPEC;
            r.full_range = hi - lo;
            r.overflow   = over;
            if (r.full_range > spec)
            begin
                spread = (count >= 2) ? hi - lo2 : '0;
                if (spread < spec)
                begin
                    r.verdict     = VERDICT_DROP_MIN;
                    r.first_index = lo_pos;
                end
                else if (spread == spec)
                    r.verdict = VERDICT_TIE;
                else
                begin
                    spread = (count >= 2) ? hi2 - lo : '0;
                    if (spread < spec)
                    begin
                        r.verdict     = VERDICT_DROP_MAX;
                        r.first_index = hi_pos;
                    end
                    else if (spread == spec)
                        r.verdict = VERDICT_TIE;
                    else
                    begin
                        spread = (count >= 3 && hi2 >= lo2) ? hi2 - lo2 : '0;
                        if (spread < spec)
                        begin
                            r.verdict      = VERDICT_DROP_BOTH;
                            r.first_index  = hi_pos;
                            r.second_index = lo_pos;
                        end
                        else if (spread == spec)
                            r.verdict = VERDICT_TIE;
                        else
                            r.verdict = VERDICT_UNCORRECTABLE;
                    end
                end
            end
            return r;
        endfunction

        function void note_sample(sample_t s);
            logic [HEIGHT_W-1:0] h;
            h = s.height;
            if (count >= MAX_SAMPLES)
                over = 1'b1;
            else
            begin
                if (count == 0)
                begin
                    lo     = h;
                    hi     = h;
                    lo2    = '1;
                    hi2    = '0;
                    lo_pos = '0;
                    hi_pos = '0;
                end
                else
                begin
                    if (h < lo)
                    begin
                        lo2    = lo;
                        lo     = h;
                        lo_pos = INDEX_W'(count);
                    end
                    else if (h < lo2)
                        lo2 = h;
                    if (h > hi)
                    begin
                        hi2    = hi;
                        hi     = h;
                        hi_pos = INDEX_W'(count);
                    end
                    else if (h > hi2)
                        hi2 = h;
                end
                count++;
            end
            if (s.last)
            begin
                due = {due, judge_set()};
                clear_set();
            end
        endfunction

        task check_verdict(result_t got);
            result_t want;
            if (due.size() == 0)
            begin
                report($sformatf("result with no set closed, verdict %0d", got.verdict));
                return;
            end
            want = due.pop_front();
            if (got.verdict !== want.verdict)
                report($sformatf("verdict %0d, want %0d", got.verdict, want.verdict));
            if (got.first_index !== want.first_index)
                report($sformatf("first_index %0d, want %0d",
                                 got.first_index, want.first_index));
            if (got.second_index !== want.second_index)
                report($sformatf("second_index %0d, want %0d",
                                 got.second_index, want.second_index));
            if (got.full_range !== want.full_range)
                report($sformatf("full_range %0d, want %0d",
                                 got.full_range, want.full_range));
            if (got.overflow !== want.overflow)
                report($sformatf("overflow %0b, want %0b", got.overflow, want.overflow));
        endtask
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              sample_valid = 1'b0;
    logic              sample_stall;
    sample_t           sample = '0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    result_t           result;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [SPEC_W-1:0] cfg_data = '0;

    spread_verdicts    sb = new();
    bit                idle_on = 1'b0;
    int                items_sent = 0;
    int                cycles = 0;

    extreme_trim_spec_check i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[extreme_trim_spec_check] ERROR");
            $finish;
        end
    end

    // Result side: check what was accepted at this edge, then pick the next stall.
    initial
    begin
        int stall_left;
        stall_left = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && result_stall === 1'b0)
                sb.check_verdict(result);
            if (stall_left > 0)
                stall_left--;
            else if (idle_on && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 10);
            result_stall <= (stall_left > 0);
        end
    end

    function automatic logic [HEIGHT_W-1:0] clamp16(input int v);
        if (v < 0)
            return '0;
        if (v > 65535)
            return '1;
        return HEIGHT_W'(v);
    endfunction

    task automatic send_sample(input logic [HEIGHT_W-1:0] h, input logic lst);
        sample_t s;
        if (idle_on && $urandom_range(0, 7) == 0)
        begin
            sample_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s.height = h;
        s.last   = lst;
        sample_valid <= 1'b1;
        sample       <= s;
        do @(posedge clk); while (sample_stall !== 1'b0);
        sb.note_sample(s);
        items_sent++;
    endtask

    // Hold off the sender until every set has been judged.
    task automatic drain();
        sample_valid <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_spec(input logic [SPEC_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.spec = v;
        cfg_valid <= 1'b0;
    endtask

    task automatic send_list(input int hs[]);
        foreach (hs[i])
            send_sample(clamp16(hs[i]), i == hs.size() - 1);
    endtask

    // One set: a cluster sized against the spec, with outliers on either side.
    task automatic send_set(input int n);
        int s, w, base, p_lo, p_hi, roll, v;
        s = sb.spec;
        case ($urandom_range(0, 3))
            0: w = s;
            1: w = $urandom_range(0, s);
            2: w = s + $urandom_range(0, s / 8 + 2);
            default: w = $urandom_range(0, 65535);
        endcase
        if (w > 65535)
            w = 65535;
        base = $urandom_range(0, 65535 - w);
        p_lo = $urandom_range(0, 1) ? $urandom_range(0, n - 1) : -1;
        p_hi = $urandom_range(0, 1) ? $urandom_range(0, n - 1) : -1;
        if (n > 255 && $urandom_range(0, 1))
            p_hi = 255;
        roll = $urandom_range(0, 9);
        for (int i = 0; i < n; i++)
        begin
            if (roll == 0)
                v = $urandom_range(0, 3) == 0 ? 65535 * $urandom_range(0, 1)
                                              : $urandom_range(0, 65535);
            else if (i == p_lo || $urandom_range(0, 11) == 0)
                v = base - $urandom_range(1, s / 2 + 50);
            else if (i == p_hi || $urandom_range(0, 11) == 0)
                v = base + w + $urandom_range(1, s / 2 + 50);
            else if ($urandom_range(0, 3) == 0)
                v = $urandom_range(0, 1) ? base : base + w;
            else
                v = base + $urandom_range(0, w);
            send_sample(clamp16(v), i == n - 1);
        end
    endtask

    initial
    begin
        int phase, phase_items;
        int spec_plan[8];
        spec_plan = '{0, 65535, 1, 1000, 500, 3000, 20, 40000};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sets under the reset spec of 1000.
        idle_on = 1'b1;
        send_list('{0});
        send_list('{65535});
        send_list('{0, 65535});
        send_list('{500, 1500, 1600, 1400});
        send_list('{100, 200, 1500});
        send_list('{0, 3000, 1000, 1500});
        send_list('{0, 2000, 4000, 6000});
        send_list('{0, 1000, 2000});
        drain();

        phase = 0;
        while (items_sent < ITEM_TARGET)
        begin
            write_spec(phase < 8 ? SPEC_W'(spec_plan[phase]) : SPEC_W'($urandom_range(0, 65535)));
            idle_on = (items_sent < QUIET_AFTER) && (phase % 4 != 3);
            phase_items = 0;
            if (phase == 2)
            begin
                send_set(MAX_SAMPLES);
                phase_items += MAX_SAMPLES;
            end
            if (phase == 5)
            begin
                phase_items += 264;
                send_set($urandom_range(MAX_SAMPLES + 1, MAX_SAMPLES + 8));
            end
            while (phase_items < 110 && items_sent < ITEM_TARGET)
            begin
                int n;
                n = $urandom_range(0, 5) == 0 ? $urandom_range(1, 3) : $urandom_range(1, 12);
                if (items_sent >= QUIET_AFTER)
                    idle_on = 1'b0;
                send_set(n);
                phase_items += n;
            end
            drain();
            phase++;
        end

        if (sb.errors == 0 && sb.due.size() == 0)
            $display("[extreme_trim_spec_check] OK");
        else
            $display("[extreme_trim_spec_check] ERROR");
        $finish;
    end

endmodule
